// File: rtl/core/stopwatch_controller_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stopwatch controller checker
// ----------------------------------------------------------------------------
`ifndef STOPWATCH_CONTROLLER_TOP_ASSERT_SVH
`define STOPWATCH_CONTROLLER_TOP_ASSERT_SVH

// Check that a condition implies a consequence in the same cycle
`define STPW_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle
`define STPW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/stpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpw_pkg
// Shared types, constants and digit helpers for the stopwatch controller.
// ----------------------------------------------------------------------------
package stpw_pkg;

  // Operating modes
  typedef enum logic [1:0] {
    MODE_STOP  = 2'd0,
    MODE_RUN   = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  // Register map (index is paddr bit 2)
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;
  localparam logic        REG_TICK  = 1'b0;
  localparam logic        REG_CHASE = 1'b1;

  localparam int unsigned PERIOD_W         = 10;
  localparam logic [PERIOD_W-1:0] TICK_RST  = 10'd100;
  localparam logic [PERIOD_W-1:0] CHASE_RST = 10'd100;

  // LED patterns
  localparam logic [7:0] CHASE_INIT  = 8'h01;
  localparam logic [7:0] STATUS_STOP = 8'h20;
  localparam logic [7:0] STATUS_RUN  = 8'h80;

  // Reciprocals for dividing now_ms/4 by 25 and by 125 (exact for 30-bit values)
  localparam logic [29:0] RECIP_25     = 30'd687194768;
  localparam int unsigned SHIFT_25     = 34;
  localparam logic [30:0] RECIP_125    = 31'd1099511628;
  localparam int unsigned SHIFT_125    = 37;

  typedef struct packed {
    logic [PERIOD_W-1:0] tick_period_ms;
    logic [PERIOD_W-1:0] chase_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        run_stop_pressed;
    logic        clear_pressed;
  } in_item_t;

  // Poll after the dot stage
  typedef struct packed {
    logic [31:0] now_ms;
    logic        run_stop_pressed;
    logic        clear_pressed;
    logic        dot_slow;
    logic        dot_fast;
  } mid_item_t;

  typedef struct packed {
    logic [3:0] digit_min_ones;
    logic [2:0] digit_sec_tens;
    logic [3:0] digit_sec_ones;
    logic [3:0] digit_tenths;
    logic       dot_slow;
    logic       dot_fast;
    logic [7:0] led_chase;
    logic [7:0] led_status;
    logic [1:0] mode_now;
    logic [4:0] hours_now;
  } out_item_t;

  // Tens digit of a value 0..59
  function automatic logic [2:0] tens_digit(input logic [5:0] v);
    logic [2:0] t;
    begin
      if (v >= 6'd50)      t = 3'd5;
      else if (v >= 6'd40) t = 3'd4;
      else if (v >= 6'd30) t = 3'd3;
      else if (v >= 6'd20) t = 3'd2;
      else if (v >= 6'd10) t = 3'd1;
      else                 t = 3'd0;
      return t;
    end
  endfunction

  // Ones digit of a value 0..59
  function automatic logic [3:0] ones_digit(input logic [5:0] v);
    logic [5:0] rem;
    begin
      rem = v - (6'(tens_digit(v)) * 6'd10);
      return rem[3:0];
    end
  endfunction

endpackage

// File: rtl/core/stopwatch_controller_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stopwatch_controller_top
// Run/stop/clear stopwatch fed by millisecond polls, with display and LEDs.
// ----------------------------------------------------------------------------
//  channel  | signals                              | item
//  ---------+--------------------------------------+----------------------
//  poll in  | in_valid_i, in_stall_o, in_item_i    | now_ms, two buttons
//  result   | out_valid_o, out_stall_i, out_item_o | digits, dots, LEDs
//  config   | psel, penable, pwrite, paddr, pwdata | two 10-bit periods
//
// One item per cycle sustained while out_stall_i is low, through the input register,
// blink dot multiply stage, then the state update into the result register.
// Reset returns to STOP with zero time and both periods at 100 ms.
// A stalled result holds; the pipeline keeps taking polls until its three
// stages are full, then raises in_stall_o.
// ----------------------------------------------------------------------------
module stopwatch_controller_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  stpw_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output stpw_pkg::out_item_t           out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [stpw_pkg::PADDR_W-1:0]  paddr,
  input  logic [stpw_pkg::PDATA_W-1:0]  pwdata,
  output logic [stpw_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  stpw_pkg::cfg_t      cfg_q;
  stpw_pkg::in_item_t  in_q;
  stpw_pkg::mid_item_t mid_q, mid_d;
  logic in_valid_q, mid_valid_q, out_valid_q;
  logic in_ready, mid_ready, out_ready, step;
  logic dot_slow, dot_fast;
  logic cfg_wr;

  // Configuration writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tick_period_ms  <= stpw_pkg::TICK_RST;
      cfg_q.chase_period_ms <= stpw_pkg::CHASE_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        stpw_pkg::REG_TICK:  cfg_q.tick_period_ms  <= pwdata[stpw_pkg::PERIOD_W-1:0];
        stpw_pkg::REG_CHASE: cfg_q.chase_period_ms <= pwdata[stpw_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (paddr[2])
      stpw_pkg::REG_TICK:  prdata = stpw_pkg::PDATA_W'(cfg_q.tick_period_ms);
      stpw_pkg::REG_CHASE: prdata = stpw_pkg::PDATA_W'(cfg_q.chase_period_ms);
      default:             prdata = '0;
    endcase
  end

  // Pipeline flow control
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign mid_ready  = !mid_valid_q || out_ready;
  assign in_ready   = !in_valid_q || mid_ready;
  assign step       = mid_valid_q && out_ready;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready)  in_valid_q  <= in_valid_i;
      if (mid_ready) mid_valid_q <= in_valid_q;
      if (out_ready) out_valid_q <= mid_valid_q;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_q <= in_item_i;
    end
  end

  // Blink dot stage
  stpw_dots u_dots (
    .now_ms_i   (in_q.now_ms),
    .dot_slow_o (dot_slow),
    .dot_fast_o (dot_fast)
  );

  always_comb begin
    mid_d.now_ms           = in_q.now_ms;
    mid_d.run_stop_pressed = in_q.run_stop_pressed;
    mid_d.clear_pressed    = in_q.clear_pressed;
    mid_d.dot_slow         = dot_slow;
    mid_d.dot_fast         = dot_fast;
  end

  always_ff @(posedge clk_i) begin
    if (mid_ready && in_valid_q) begin
      mid_q <= mid_d;
    end
  end

  // State update and result register
  stpw_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .cfg_i    (cfg_q),
    .item_i   (mid_q),
    .result_o (out_item_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/core/stpw_dots.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpw_dots
// Blink dot phases: bit 0 of now_ms/100 and of now_ms/500.
// ----------------------------------------------------------------------------
module stpw_dots (
  input  logic [31:0] now_ms_i,
  output logic        dot_slow_o,
  output logic        dot_fast_o
);

  logic [29:0] quarter;
  logic [59:0] prod_fast;
  logic [60:0] prod_slow;

  // Divide by 4 first, then by 25 or 125 through a reciprocal multiply
  assign quarter   = now_ms_i[31:2];
  assign prod_fast = 60'(quarter) * 60'(stpw_pkg::RECIP_25);
  assign prod_slow = 61'(quarter) * 61'(stpw_pkg::RECIP_125);

  assign dot_fast_o = prod_fast[stpw_pkg::SHIFT_25];
  assign dot_slow_o = prod_slow[stpw_pkg::SHIFT_125];

endmodule

// File: rtl/core/stpw_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpw_core
// Stopwatch state: time counters, mode, LED patterns and the result register.
// ----------------------------------------------------------------------------
module stpw_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  stpw_pkg::cfg_t       cfg_i,
  input  stpw_pkg::mid_item_t  item_i,
  output stpw_pkg::out_item_t  result_o
);

  stpw_pkg::mode_e mode_q, mode_d;
  logic [3:0]  tenths_q, tenths_d, tenths_a;
  logic [5:0]  seconds_q, seconds_d, seconds_a;
  logic [5:0]  minutes_q, minutes_d, minutes_a;
  logic [4:0]  hours_q, hours_d, hours_a;
  logic [31:0] last_tick_q, last_tick_d;
  logic [31:0] last_chase_q, last_chase_d;
  logic [7:0]  chase_q, chase_d, chase_b;
  logic [7:0]  status_d;
  logic [31:0] tick_diff, chase_diff;
  logic        tick_due, chase_due;
  stpw_pkg::out_item_t result_d, result_q;

  // Elapsed time since the last tick and the last rotation
  assign tick_diff  = item_i.now_ms - last_tick_q;
  assign chase_diff = item_i.now_ms - last_chase_q;
  assign tick_due   = tick_diff >= 32'(cfg_i.tick_period_ms);
  assign chase_due  = chase_diff >= 32'(cfg_i.chase_period_ms);
  assign last_tick_d = tick_due ? item_i.now_ms : last_tick_q;

  // Advance time by one tenth on a tick in the old RUN mode
  always_comb begin
    tenths_a  = tenths_q;
    seconds_a = seconds_q;
    minutes_a = minutes_q;
    hours_a   = hours_q;
    if (tick_due && (mode_q == stpw_pkg::MODE_RUN)) begin
      if (tenths_q == 4'd9) begin
        tenths_a = 4'd0;
        if (seconds_q == 6'd59) begin
          seconds_a = 6'd0;
          if (minutes_q == 6'd59) begin
            minutes_a = 6'd0;
            hours_a   = (hours_q == 5'd23) ? 5'd0 : hours_q + 5'd1;
          end else begin
            minutes_a = minutes_q + 6'd1;
          end
        end else begin
          seconds_a = seconds_q + 6'd1;
        end
      end else begin
        tenths_a = tenths_q + 4'd1;
      end
    end
  end

  // Next mode
  always_comb begin
    case (mode_q)
      stpw_pkg::MODE_RUN: begin
        mode_d = item_i.run_stop_pressed ? stpw_pkg::MODE_STOP : stpw_pkg::MODE_RUN;
      end
      stpw_pkg::MODE_CLEAR: begin
        mode_d = stpw_pkg::MODE_STOP;
      end
      stpw_pkg::MODE_STOP: begin
        if (item_i.run_stop_pressed)   mode_d = stpw_pkg::MODE_RUN;
        else if (item_i.clear_pressed) mode_d = stpw_pkg::MODE_CLEAR;
        else                           mode_d = stpw_pkg::MODE_STOP;
      end
      default: begin
        mode_d = stpw_pkg::MODE_STOP;
      end
    endcase
  end

  // Clear time on leaving CLEAR, then update the LEDs from the new mode
  always_comb begin
    if (mode_q == stpw_pkg::MODE_CLEAR) begin
      tenths_d  = 4'd0;
      seconds_d = 6'd0;
      minutes_d = 6'd0;
      hours_d   = 5'd0;
      chase_b   = stpw_pkg::CHASE_INIT;
    end else begin
      tenths_d  = tenths_a;
      seconds_d = seconds_a;
      minutes_d = minutes_a;
      hours_d   = hours_a;
      chase_b   = chase_q;
    end
    last_chase_d = last_chase_q;
    chase_d      = chase_b;
    status_d     = stpw_pkg::STATUS_STOP;
    case (mode_d)
      stpw_pkg::MODE_RUN: begin
        status_d = stpw_pkg::STATUS_RUN;
        if (chase_due) begin
          last_chase_d = item_i.now_ms;
          chase_d      = {chase_b[6:0], chase_b[7]};
        end
      end
      stpw_pkg::MODE_CLEAR: begin
        chase_d = stpw_pkg::CHASE_INIT;
      end
      default: begin
        status_d = stpw_pkg::STATUS_STOP;
      end
    endcase
  end

  // Assemble the result item
  always_comb begin
    result_d.digit_min_ones = stpw_pkg::ones_digit(minutes_d);
    result_d.digit_sec_tens = stpw_pkg::tens_digit(seconds_d);
    result_d.digit_sec_ones = stpw_pkg::ones_digit(seconds_d);
    result_d.digit_tenths   = tenths_d;
    result_d.dot_slow       = (mode_d == stpw_pkg::MODE_RUN) && item_i.dot_slow;
    result_d.dot_fast       = (mode_d == stpw_pkg::MODE_RUN) && item_i.dot_fast;
    result_d.led_chase      = chase_d;
    result_d.led_status     = status_d;
    result_d.mode_now       = mode_d;
    result_d.hours_now      = hours_d;
  end

  // Hold state between items
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= stpw_pkg::MODE_STOP;
      tenths_q     <= 4'd0;
      seconds_q    <= 6'd0;
      minutes_q    <= 6'd0;
      hours_q      <= 5'd0;
      last_tick_q  <= 32'd0;
      last_chase_q <= 32'd0;
      chase_q      <= stpw_pkg::CHASE_INIT;
    end else if (step_i) begin
      mode_q       <= mode_d;
      tenths_q     <= tenths_d;
      seconds_q    <= seconds_d;
      minutes_q    <= minutes_d;
      hours_q      <= hours_d;
      last_tick_q  <= last_tick_d;
      last_chase_q <= last_chase_d;
      chase_q      <= chase_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

// File: rtl/core/stpw_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpw_checker
// Port-level checks on the stopwatch controller results.
// ----------------------------------------------------------------------------
`include "stopwatch_controller_top_assert.svh"

module stpw_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input stpw_pkg::out_item_t           out_item_o
);

  logic res_run;
  assign res_run = out_item_o.mode_now == 2'(stpw_pkg::MODE_RUN);

  // A stalled result item holds
  `STPW_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(out_item_o), "stalled result item changed")

  // The chase pattern stays one-hot
  `STPW_ASSERT_NOW(a_chase_onehot, clk_i, rst_ni, out_valid_o,
    $onehot(out_item_o.led_chase), "chase pattern is not one-hot")

  // Status LED and dots follow the mode
  `STPW_ASSERT_NOW(a_run_status, clk_i, rst_ni, out_valid_o && res_run,
    out_item_o.led_status == stpw_pkg::STATUS_RUN, "status LED wrong in RUN")

  `STPW_ASSERT_NOW(a_idle_leds, clk_i, rst_ni, out_valid_o && !res_run,
    (out_item_o.led_status == stpw_pkg::STATUS_STOP) && !out_item_o.dot_slow &&
    !out_item_o.dot_fast, "status LED or dots wrong outside RUN")

  // Entering CLEAR resets the chase
  `STPW_ASSERT_NOW(a_clear_chase, clk_i, rst_ni,
    out_valid_o && (out_item_o.mode_now == 2'(stpw_pkg::MODE_CLEAR)),
    out_item_o.led_chase == stpw_pkg::CHASE_INIT, "chase not reset in CLEAR")

endmodule

bind stopwatch_controller_top stpw_checker u_stpw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
